@@ src/clcd_pkg.sv @@
// ----------------------------------------------------------------------------
// clcd_pkg: shared types and constants of the character-LCD text writer
// Holds the byte record passed from the front to the back, the DDRAM row
// bases and the helpers that build a cursor-set command.
// ----------------------------------------------------------------------------
package clcd_pkg;

	localparam logic [2:0] MAX_ROWS = 3'd4;
	localparam logic [7:0] CHAR_LF = 8'h0A;
	localparam logic [7:0] CHAR_CR = 8'h0D;
	localparam logic       RS_INSTR = 1'b0;
	localparam logic       RS_DATA = 1'b1;
	localparam logic       MODE_TEXT = 1'b0;
	localparam logic       MODE_CURSOR = 1'b1;
	localparam logic       REG_DISPLAY_COLS = 1'b0;
	localparam logic       REG_DISPLAY_ROWS = 1'b1;
	localparam logic [7:0] CMD_SET_DDRAM = 8'h80;
	localparam logic [6:0] ROW_BASE [4] = '{7'h00, 7'h40, 7'h14, 7'h54};

	// One or two bytes caused by one input word. The optional first byte is
	// always an instruction (the wrap cursor set).
	typedef struct packed {
		logic       two_bytes;
		logic [7:0] first_byte;
		logic       rs;
		logic [7:0] main_byte;
	} clcd_rec_t;

	function automatic logic [1:0] clcd_norm_row(logic [2:0] row, logic [2:0] lim);
		logic [1:0] res;
		res = (row >= lim) ? 2'd0 : row[1:0];
		return res;
	endfunction

	function automatic logic [7:0] clcd_cmd(logic [5:0] col, logic [1:0] row);
		logic [6:0] addr;
		addr = {1'b0, col} + ROW_BASE[row];
		return CMD_SET_DDRAM | {1'b0, addr};
	endfunction

endpackage

@@ src/clcd_front.sv @@
// ----------------------------------------------------------------------------
// clcd_front: input stage and cursor tracking
// Accepts one word per cycle while accept is high, updates the cursor and
// config state and builds the byte record the back stage turns to nibbles.
// ----------------------------------------------------------------------------
module clcd_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_wr_en,
	input  logic                cfg_index,
	input  logic [5:0]          cfg_wdata,
	input  logic                accept,
	input  logic                mode,
	input  logic [7:0]          char_code,
	input  logic [5:0]          cursor_col,
	input  logic [1:0]          cursor_row,
	output clcd_pkg::clcd_rec_t rec
);
	import clcd_pkg::*;

	logic [5:0] display_cols_q;
	logic [2:0] display_rows_q;
	logic [5:0] col_q;
	logic [1:0] line_q;
	logic [5:0] col_next;
	logic [1:0] line_next;
	logic [2:0] lim;
	logic       wrap;
	logic [1:0] r_wrap;
	logic [5:0] col_a;
	logic [1:0] line_a;
	logic [1:0] r_new;

	always_comb begin
		lim = (display_rows_q < MAX_ROWS) ? display_rows_q : MAX_ROWS;
		wrap = col_q >= display_cols_q;
		r_wrap = clcd_norm_row({1'b0, line_q} + 3'd1, lim);
		col_a = wrap ? 6'd0 : col_q;
		line_a = wrap ? r_wrap : line_q;
		rec.first_byte = clcd_cmd(6'd0, r_wrap);
		rec.two_bytes = 1'b0;
		rec.rs = RS_INSTR;
		r_new = 2'd0;
		if (mode == MODE_CURSOR) begin
			r_new = clcd_norm_row({1'b0, cursor_row}, lim);
			rec.main_byte = clcd_cmd(cursor_col, r_new);
			col_next = cursor_col;
			line_next = r_new;
		end else begin
			rec.two_bytes = wrap;
			unique case (char_code)
				CHAR_LF: begin
					r_new = clcd_norm_row({1'b0, line_a} + 3'd1, lim);
					rec.main_byte = clcd_cmd(col_a, r_new);
					col_next = col_a;
					line_next = r_new;
				end
				CHAR_CR: begin
					r_new = clcd_norm_row({1'b0, line_a}, lim);
					rec.main_byte = clcd_cmd(6'd0, r_new);
					col_next = 6'd0;
					line_next = r_new;
				end
				default: begin
					rec.rs = RS_DATA;
					rec.main_byte = char_code;
					col_next = col_a + 6'd1;
					line_next = line_a;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			display_cols_q <= 6'd16;
			display_rows_q <= 3'd2;
			col_q <= 6'd0;
			line_q <= 2'd0;
		end else begin
			if (cfg_wr_en) begin
				unique case (cfg_index)
					REG_DISPLAY_COLS: display_cols_q <= cfg_wdata;
					REG_DISPLAY_ROWS: display_rows_q <= cfg_wdata[2:0];
					default: ;
				endcase
			end
			if (accept) begin
				col_q <= col_next;
				line_q <= line_next;
			end
		end
	end

endmodule

@@ src/clcd_queue.sv @@
// ----------------------------------------------------------------------------
// clcd_queue: short record queue between front and back
// A small register file with read and write pointers and a fill count.
// ----------------------------------------------------------------------------
module clcd_queue #(
	parameter int DEPTH = 2
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                wr,
	input  clcd_pkg::clcd_rec_t wdata,
	output logic                full,
	input  logic                rd,
	output logic                valid,
	output clcd_pkg::clcd_rec_t rdata
);
	import clcd_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	clcd_rec_t     mem_q [DEPTH];
	logic [PW-1:0] wptr_q;
	logic [PW-1:0] rptr_q;
	logic [CW-1:0] count_q;
	logic          do_wr;
	logic          do_rd;

	assign full = count_q == FULL_CNT;
	assign valid = count_q != '0;
	assign rdata = mem_q[rptr_q];
	assign do_wr = wr && !full;
	assign do_rd = rd && valid;

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_wr) begin
				wptr_q <= (wptr_q == LAST_PTR) ? '0 : wptr_q + PW'(1);
			end
			if (do_rd) begin
				rptr_q <= (rptr_q == LAST_PTR) ? '0 : rptr_q + PW'(1);
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + CW'(1);
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

@@ src/clcd_back.sv @@
// ----------------------------------------------------------------------------
// clcd_back: nibble sequencer and output register
// Splits each record into two or four nibbles, high nibble first, and holds
// the oldest nibble in an output register until it is popped.
// ----------------------------------------------------------------------------
module clcd_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                q_valid,
	input  clcd_pkg::clcd_rec_t q_rec,
	output logic                q_rd,
	input  logic                pop,
	output logic                empty,
	output logic                reg_select,
	output logic [3:0]          nibble,
	output logic                last
);
	import clcd_pkg::*;

	clcd_rec_t  rec_q;
	logic       rec_valid_q;
	logic [1:0] step_q;
	logic       out_valid_q;
	logic       advance;
	logic       on_first;
	logic [7:0] cur_byte;
	logic       cur_rs;
	logic       cur_last;

	always_comb begin
		advance = !out_valid_q || pop;
		on_first = rec_q.two_bytes && !step_q[1];
		cur_byte = on_first ? rec_q.first_byte : rec_q.main_byte;
		cur_rs = on_first ? RS_INSTR : rec_q.rs;
		cur_last = rec_q.two_bytes ? (step_q == 2'd3) : (step_q == 2'd1);
		q_rd = q_valid && (!rec_valid_q || (advance && cur_last));
	end

	assign empty = !out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rec_valid_q <= 1'b0;
			step_q <= 2'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				out_valid_q <= rec_valid_q;
				if (rec_valid_q) begin
					step_q <= cur_last ? 2'd0 : step_q + 2'd1;
				end
			end
			if (q_rd) begin
				rec_valid_q <= 1'b1;
			end else if (advance && cur_last) begin
				rec_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_rd) begin
			rec_q <= q_rec;
		end
		if (advance && rec_valid_q) begin
			reg_select <= cur_rs;
			nibble <= step_q[0] ? cur_byte[3:0] : cur_byte[7:4];
			last <= cur_last;
		end
	end

endmodule

@@ src/char_lcd_text_cursor_writer.sv @@
// ----------------------------------------------------------------------------
// char_lcd_text_cursor_writer: text and cursor stream to 4-bit LCD bus writes
//
//   Channel   Signals                                     Word accepted when
//   input     push full mode char_code cursor_col/row     push && !full
//   result    empty pop reg_select nibble last            pop && !empty
//   config    cfg_wr_en cfg_index cfg_wdata               cfg_wr_en
//
// The front takes one word per cycle while the record queue has room. Each
// word yields two or four nibbles, sent one per cycle by the back stage
// unless pop stalls, so the output register paces the word stream. Reset
// clears the cursor to column zero of row zero and loads 16 columns and 2
// rows. A stalled pop holds the result and backs up into the queue, which
// then raises full.
// ----------------------------------------------------------------------------
module char_lcd_text_cursor_writer #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_wr_en,
	input  logic       cfg_index,
	input  logic [5:0] cfg_wdata,
	input  logic       push,
	output logic       full,
	input  logic       mode,
	input  logic [7:0] char_code,
	input  logic [5:0] cursor_col,
	input  logic [1:0] cursor_row,
	output logic       empty,
	input  logic       pop,
	output logic       reg_select,
	output logic [3:0] nibble,
	output logic       last
);
	import clcd_pkg::*;

	clcd_rec_t front_rec;
	clcd_rec_t q_rec;
	logic      accept;
	logic      q_valid;
	logic      q_rd;

	assign accept = push && !full;

	clcd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.accept     (accept),
		.mode       (mode),
		.char_code  (char_code),
		.cursor_col (cursor_col),
		.cursor_row (cursor_row),
		.rec        (front_rec)
	);

	clcd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (accept),
		.wdata  (front_rec),
		.full   (full),
		.rd     (q_rd),
		.valid  (q_valid),
		.rdata  (q_rec)
	);

	clcd_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_valid    (q_valid),
		.q_rec      (q_rec),
		.q_rd       (q_rd),
		.pop        (pop),
		.empty      (empty),
		.reg_select (reg_select),
		.nibble     (nibble),
		.last       (last)
	);

endmodule

@@ tb/sv/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: regression for char_lcd_text_cursor_writer
// Sends text characters and cursor-set words through the push/full side while
// the column and row registers move through several settings, and predicts
// each 4-bit bus write from a cursor model kept in the bench. Every nibble
// popped is checked in order against the predicted register select, nibble
// and last flag. Sender gaps and receiver stalls vary over the run.
// ----------------------------------------------------------------------------
module tb;

	import clcd_pkg::*;

	typedef struct packed {
		logic       rs;
		logic [3:0] nib;
		logic       last;
	} lcd_write_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       cfg_wr_en = 1'b0;
	logic       cfg_index = REG_DISPLAY_COLS;
	logic [5:0] cfg_wdata = 6'd0;
	logic       push = 1'b0;
	logic       full;
	logic       mode = MODE_TEXT;
	logic [7:0] char_code = 8'd0;
	logic [5:0] cursor_col = 6'd0;
	logic [1:0] cursor_row = 2'd0;
	logic       empty;
	logic       pop = 1'b0;
	logic       reg_select;
	logic [3:0] nibble;
	logic       last;

	char_lcd_text_cursor_writer DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.push(push),
		.full(full),
		.mode(mode),
		.char_code(char_code),
		.cursor_col(cursor_col),
		.cursor_row(cursor_row),
		.empty(empty),
		.pop(pop),
		.reg_select(reg_select),
		.nibble(nibble),
		.last(last)
	);

	// Cursor model and display geometry as the block should hold them.
	logic [5:0] cfg_cols = 6'd16;
	logic [2:0] cfg_rows = 3'd2;
	logic [5:0] cur_col = 6'd0;
	logic [1:0] cur_line = 2'd0;

	lcd_write_t word_writes[$];
	lcd_write_t expected_writes[$];

	int errors = 0;
	int n_words = 0;
	int n_nibbles = 0;
	int n_settings = 0;
	int burst_left = 0;
	int rx_cycle = 0;

	initial begin
		forever #1 clk = ~clk;
	end

	initial begin
		#1_000_000;
		$display("char_lcd_text_cursor_writer regression: fail");
		$finish;
	end

	function automatic void add_byte(logic rs, logic [7:0] b);
		word_writes.push_back('{rs, b[7:4], 1'b0});
		word_writes.push_back('{rs, b[3:0], 1'b0});
	endfunction

	function automatic void add_cursor_set(logic [5:0] col, logic [2:0] row);
		logic [2:0] lim;
		logic [6:0] addr;
		lim = (cfg_rows < MAX_ROWS) ? cfg_rows : MAX_ROWS;
		if (row >= lim)
			row = 3'd0;
		cur_col = col;
		cur_line = row[1:0];
		addr = {1'b0, col} + ROW_BASE[row[1:0]];
		add_byte(RS_INSTR, CMD_SET_DDRAM | {1'b0, addr});
	endfunction

	function automatic void predict_word(logic m, logic [7:0] ch, logic [5:0] col,
			logic [1:0] row);
		lcd_write_t w;
		word_writes.delete();
		if (m == MODE_CURSOR) begin
			add_cursor_set(col, {1'b0, row});
		end else begin
			if (cur_col >= cfg_cols)
				add_cursor_set(6'd0, {1'b0, cur_line} + 3'd1);
			if (ch == CHAR_LF) begin
				add_cursor_set(cur_col, {1'b0, cur_line} + 3'd1);
			end else if (ch == CHAR_CR) begin
				add_cursor_set(6'd0, {1'b0, cur_line});
			end else begin
				add_byte(RS_DATA, ch);
				cur_col = cur_col + 6'd1;
			end
		end
		w = word_writes.pop_back();
		w.last = 1'b1;
		word_writes.push_back(w);
		foreach (word_writes[i])
			expected_writes.push_back(word_writes[i]);
	endfunction

	// The receiver cycles through steady popping, light and heavy random
	// stalls, and a fixed on/off pattern.
	always @(posedge clk) begin : nibble_check
		lcd_write_t got;
		lcd_write_t want;
		if (arst_n && pop && empty === 1'b0) begin
			got = '{reg_select, nibble, last};
			n_nibbles++;
			if (expected_writes.size() == 0) begin
				errors++;
				$display("%0t: unexpected word rs=%0b nibble=%h last=%0b",
					$time, got.rs, got.nib, got.last);
			end else begin
				want = expected_writes.pop_front();
				if (got !== want) begin
					errors++;
					$display({"%0t: expected rs=%0b nibble=%h last=%0b,",
						" got rs=%0b nibble=%h last=%0b"},
						$time, want.rs, want.nib, want.last, got.rs, got.nib, got.last);
				end
			end
		end
		rx_cycle++;
		case ((rx_cycle / 150) % 4)
			0: pop <= 1'b1;
			1: pop <= ($urandom_range(0, 1) == 1);
			2: pop <= ($urandom_range(0, 4) == 0);
			default: pop <= ((rx_cycle % 16) < 5);
		endcase
	end

	task automatic send_word(logic m, logic [7:0] ch, logic [5:0] col, logic [1:0] row);
		int gap;
		if (burst_left == 0) begin
			gap = int'($urandom_range(0, 6));
			if (gap != 0) begin
				push <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = ($urandom_range(0, 3) == 0) ? int'($urandom_range(20, 40))
				: int'($urandom_range(1, 8));
		end
		burst_left--;
		push <= 1'b1;
		mode <= m;
		char_code <= ch;
		cursor_col <= col;
		cursor_row <= row;
		@(posedge clk);
		while (full !== 1'b0)
			@(posedge clk);
		predict_word(m, ch, col, row);
		n_words++;
	endtask

	task automatic wait_until_drained();
		push <= 1'b0;
		while (expected_writes.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		burst_left = 0;
	endtask

	task automatic set_geometry(logic [5:0] cols, logic [5:0] rows_data);
		wait_until_drained();
		cfg_wr_en <= 1'b1;
		cfg_index <= REG_DISPLAY_COLS;
		cfg_wdata <= cols;
		@(posedge clk);
		cfg_cols = cols;
		cfg_index <= REG_DISPLAY_ROWS;
		cfg_wdata <= rows_data;
		@(posedge clk);
		cfg_rows = rows_data[2:0];
		cfg_wr_en <= 1'b0;
		n_settings++;
	endtask

	task automatic test_reset_geometry_text();
		send_word(MODE_TEXT, 8'h48, 6'h2A, 2'd3);
		send_word(MODE_TEXT, 8'h00, 6'h15, 2'd0);
		send_word(MODE_TEXT, 8'hFF, 6'h3F, 2'd1);
		send_word(MODE_TEXT, CHAR_CR, 6'h00, 2'd2);
		send_word(MODE_TEXT, CHAR_LF, 6'h3F, 2'd3);
		send_word(MODE_TEXT, CHAR_LF, 6'h00, 2'd0);
	endtask

	task automatic test_cursor_sets();
		send_word(MODE_CURSOR, 8'h00, 6'd0, 2'd0);
		send_word(MODE_CURSOR, 8'hFF, 6'd63, 2'd3);
		set_geometry(6'd40, 6'd4);
		send_word(MODE_CURSOR, CHAR_LF, 6'd39, 2'd3);
		send_word(MODE_CURSOR, CHAR_CR, 6'd63, 2'd3);
		send_word(MODE_CURSOR, 8'hAA, 6'd5, 2'd1);
		send_word(MODE_CURSOR, 8'h55, 6'd20, 2'd2);
	endtask

	task automatic test_wrap_edges();
		set_geometry(6'd1, 6'd1);
		send_word(MODE_TEXT, 8'h61, 6'd0, 2'd0);
		send_word(MODE_TEXT, 8'h62, 6'd0, 2'd0);
		send_word(MODE_TEXT, CHAR_LF, 6'd0, 2'd0);
		send_word(MODE_TEXT, CHAR_CR, 6'd0, 2'd0);
		set_geometry(6'd0, 6'd0);
		send_word(MODE_TEXT, 8'h78, 6'd0, 2'd0);
		send_word(MODE_TEXT, 8'h79, 6'd0, 2'd0);
		send_word(MODE_TEXT, CHAR_LF, 6'd0, 2'd0);
		set_geometry(6'd63, 6'd7);
		send_word(MODE_CURSOR, 8'h00, 6'd62, 2'd3);
		send_word(MODE_TEXT, 8'h70, 6'd0, 2'd0);
		send_word(MODE_TEXT, 8'h71, 6'd0, 2'd0);
		send_word(MODE_TEXT, 8'h72, 6'd0, 2'd0);
	endtask

	task automatic test_random_traffic();
		logic [5:0] cols;
		logic [5:0] rows_data;
		logic m;
		logic [7:0] ch;
		logic [5:0] col;
		int pick;
		for (int phase = 0; phase < 10; phase++) begin
			if (phase == 0) begin
				cols = 6'd40;
				rows_data = 6'd4;
			end else if (phase == 1) begin
				cols = 6'd1;
				rows_data = 6'd1;
			end else begin
				pick = int'($urandom_range(0, 9));
				if (pick == 0)
					cols = 6'd0;
				else if (pick == 1)
					cols = 6'd63;
				else if (pick < 6)
					cols = 6'($urandom_range(1, 6));
				else
					cols = 6'($urandom_range(1, 40));
				rows_data = 6'($urandom_range(0, 63));
			end
			set_geometry(cols, rows_data);
			for (int k = 0; k < 26; k++) begin
				if (phase == 5 && k == 13)
					wait_until_drained();
				m = ($urandom_range(0, 99) < 20) ? MODE_CURSOR : MODE_TEXT;
				pick = int'($urandom_range(0, 9));
				if (pick < 2)
					ch = CHAR_LF;
				else if (pick == 2)
					ch = CHAR_CR;
				else
					ch = 8'($urandom_range(0, 255));
				if ($urandom_range(0, 3) == 0)
					col = 6'($urandom_range(0, 63));
				else
					col = 6'($urandom_range(0, 39));
				send_word(m, ch, col, 2'($urandom_range(0, 3)));
			end
		end
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_geometry_text();
		test_cursor_sets();
		test_wrap_edges();
		test_random_traffic();
		push <= 1'b0;
		while (expected_writes.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		$display("Covered %0d words and %0d nibble writes over %0d display geometries.",
			n_words, n_nibbles, n_settings);
		if (errors == 0)
			$display("char_lcd_text_cursor_writer regression: pass");
		else
			$display("char_lcd_text_cursor_writer regression: fail");
		$finish;
	end

endmodule
